// ----- hw/rtl/pmid_pkg.sv -----
// shared constants, types and width helpers for the periodic minimum-image distance core
// no dependencies
package pmid_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int BOX_BITS       = 31;
  localparam logic [BOX_BITS-1:0] BOX_RESET = 31'd655360;

  localparam int NUM_AXES  = 3;
  localparam int LANE_LAT  = 5;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z = 2'd2;

  // operation kinds
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_X   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_Y   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_Z   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_XY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_XZ  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_YZ  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_XYZ = 3'd6;
  localparam logic [KIND_W-1:0] KIND_VEC = 3'd7;

  typedef struct packed {
    logic                valid;
    logic [KIND_W-1:0]   kind;
  } ctrl_t;

  typedef struct packed {
    logic used;
    logic vec;
    logic periodic;
  } lane_ctl_t;

  // signed width for the folded difference, with headroom for the doubled compare
  function automatic int fold_w(int coord_bits);
    int w;
    w = (coord_bits + 1 > BOX_BITS + 1) ? coord_bits + 1 : BOX_BITS + 1;
    return w + 2;
  endfunction

  // width of the magnitude of a folded difference
  function automatic int mag_w(int coord_bits);
    return (coord_bits > BOX_BITS) ? coord_bits : BOX_BITS;
  endfunction

  // axes taking part in each kind, bit 0 = x
  function automatic logic [NUM_AXES-1:0] axis_mask(logic [KIND_W-1:0] kind);
    logic [NUM_AXES-1:0] m;
    case (kind)
      KIND_X:   m = 3'b001;
      KIND_Y:   m = 3'b010;
      KIND_Z:   m = 3'b100;
      KIND_XY:  m = 3'b011;
      KIND_XZ:  m = 3'b101;
      KIND_YZ:  m = 3'b110;
      KIND_XYZ: m = 3'b111;
      KIND_VEC: m = 3'b111;
      default:  m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

// ----- hw/rtl/periodic_min_image_distance_core.sv -----
// top level of the periodic minimum-image distance core
// depends on pmid_pkg, pmid_lane, pmid_merge (and pmid_isqrt below it)

// A fully pipelined unit: it takes one transaction (a particle pair and a kind)
// in every clock cycle and returns one result transaction per input, in order.
// busy_o is always low, so start_i is accepted whenever it is high. Each result
// appears for exactly one cycle with done_o high, and the receiver cannot stall
// it. Each transaction passes through the lane stages, the sum register, the
// square-root pipeline, which resolves one root bit per stage, and the output
// register. Box lengths are written on the config port and should only change
// while no transaction is in flight.
module periodic_min_image_distance_core #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [pmid_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pmid_pkg::BOX_BITS-1:0]        cfg_wdata_i,
  // command side
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [pmid_pkg::KIND_W-1:0]          kind_i,
  input  logic                                 periodic_i,
  input  logic signed [COORD_BITS-1:0]         first_x_i,
  input  logic signed [COORD_BITS-1:0]         first_y_i,
  input  logic signed [COORD_BITS-1:0]         first_z_i,
  input  logic signed [COORD_BITS-1:0]         second_x_i,
  input  logic signed [COORD_BITS-1:0]         second_y_i,
  input  logic signed [COORD_BITS-1:0]         second_z_i,
  // result side
  output logic                                 done_o,
  output logic signed [COORD_BITS+1:0]         distance_o,
  output logic signed [COORD_BITS:0]           vec_x_o,
  output logic signed [COORD_BITS:0]           vec_y_o,
  output logic signed [COORD_BITS:0]           vec_z_o,
  output logic                                 range_error_o
);

  localparam int NA = pmid_pkg::NUM_AXES;
  localparam int FW = pmid_pkg::fold_w(COORD_BITS);
  localparam int MW = pmid_pkg::mag_w(COORD_BITS);

  // box length registers
  logic [pmid_pkg::BOX_BITS-1:0] box_q [NA];

  // per-axis views of the coordinate ports
  logic signed [COORD_BITS-1:0] first_c  [NA];
  logic signed [COORD_BITS-1:0] second_c [NA];

  logic [NA-1:0]        used_mask;
  pmid_pkg::lane_ctl_t  lane_ctl [NA];

  // lane outputs
  logic signed [FW-1:0] lane_diff [NA];
  logic                 lane_err  [NA];
  logic [2*MW-1:0]      lane_sq   [NA];

  // kind and valid travel alongside the lanes
  pmid_pkg::ctrl_t ctrl_q [pmid_pkg::LANE_LAT];

  // fully pipelined, never busy
  assign busy_o = 1'b0;

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NA; i++) begin
        box_q[i] <= pmid_pkg::BOX_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pmid_pkg::REG_BOX_X: box_q[0] <= cfg_wdata_i;
        pmid_pkg::REG_BOX_Y: box_q[1] <= cfg_wdata_i;
        pmid_pkg::REG_BOX_Z: box_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign first_c[0]  = first_x_i;
  assign first_c[1]  = first_y_i;
  assign first_c[2]  = first_z_i;
  assign second_c[0] = second_x_i;
  assign second_c[1] = second_y_i;
  assign second_c[2] = second_z_i;

  // axes outside the kind are zeroed inside the lane
  assign used_mask = pmid_pkg::axis_mask(kind_i);

  for (genvar g = 0; g < NA; g++) begin : g_lane
    assign lane_ctl[g] = '{used:     used_mask[g],
                           vec:      (kind_i == pmid_pkg::KIND_VEC),
                           periodic: periodic_i};

    pmid_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .ctl_i    (lane_ctl[g]),
      .box_i    (box_q[g]),
      .first_i  (first_c[g]),
      .second_i (second_c[g]),
      .diff_o   (lane_diff[g]),
      .err_o    (lane_err[g]),
      .sq_o     (lane_sq[g])
    );
  end

  // control delay line matching the lane depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pmid_pkg::LANE_LAT; i++) begin
        ctrl_q[i] <= '0;
      end
    end else begin
      ctrl_q[0] <= '{valid: start_i, kind: kind_i};
      for (int i = 1; i < pmid_pkg::LANE_LAT; i++) begin
        ctrl_q[i] <= ctrl_q[i-1];
      end
    end
  end

  // sum of squares, result select and root pipeline
  pmid_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl_q[pmid_pkg::LANE_LAT-1]),
    .diff_i        (lane_diff),
    .err_i         (lane_err),
    .sq_i          (lane_sq),
    .done_o        (done_o),
    .distance_o    (distance_o),
    .vec_x_o       (vec_x_o),
    .vec_y_o       (vec_y_o),
    .vec_z_o       (vec_z_o),
    .range_error_o (range_error_o)
  );

endmodule

// ----- hw/rtl/pmid_lane.sv -----
// one axis lane: difference, periodic fold, range check and pipelined square
// depends on pmid_pkg
module pmid_lane #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk_i,
  input  pmid_pkg::lane_ctl_t                           ctl_i,
  input  logic [pmid_pkg::BOX_BITS-1:0]                 box_i,
  input  logic signed [COORD_BITS-1:0]                  first_i,
  input  logic signed [COORD_BITS-1:0]                  second_i,
  output logic signed [pmid_pkg::fold_w(COORD_BITS)-1:0] diff_o,
  output logic                                          err_o,
  output logic [2*pmid_pkg::mag_w(COORD_BITS)-1:0]      sq_o
);

  localparam int FW   = pmid_pkg::fold_w(COORD_BITS);
  localparam int MW   = pmid_pkg::mag_w(COORD_BITS);
  localparam int H    = MW / 2;
  localparam int HW   = MW - H;
  localparam int SQ_W = 2 * MW;

  // stage 1: raw difference
  logic signed [FW-1:0] d1_d, d1_q;
  pmid_pkg::lane_ctl_t  ctl1_q;
  // stage 2: folded difference
  logic signed [FW-1:0] d2_d, d2_q;
  pmid_pkg::lane_ctl_t  ctl2_q;
  // stage 3: range check and magnitude
  logic signed [FW-1:0] d3_q;
  logic                 err3_d, err3_q;
  logic [MW-1:0]        mag3_d, mag3_q;
  // stage 4: partial products
  logic signed [FW-1:0] d4_q;
  logic                 err4_q;
  logic [2*HW-1:0]      hh_d, hh_q;
  logic [HW+H-1:0]      hl_d, hl_q;
  logic [2*H-1:0]       ll_d, ll_q;
  // stage 5: square
  logic signed [FW-1:0] d5_q;
  logic                 err5_q;
  logic [SQ_W-1:0]      sq5_d, sq5_q;

  logic signed [FW-1:0] box_s, nbox_s, tw1, tw2, absd;
  logic                 hi1, lo1;
  logic [HW-1:0]        mh;
  logic [H-1:0]         ml;

  assign box_s  = signed'(FW'(box_i));
  assign nbox_s = -box_s;

  always_comb begin
    if (ctl_i.vec) begin
      d1_d = FW'(second_i) - FW'(first_i);
    end else begin
      d1_d = FW'(first_i) - FW'(second_i);
    end
  end

  // fold by at most one box length; vector kind keeps the half-open range
  always_comb begin
    tw1 = d1_q <<< 1;
    hi1 = ctl1_q.vec ? (tw1 >= box_s) : (tw1 > box_s);
    lo1 = tw1 < nbox_s;
    if (!ctl1_q.used) begin
      d2_d = '0;
    end else if (ctl1_q.periodic && hi1) begin
      d2_d = d1_q - box_s;
    end else if (ctl1_q.periodic && lo1) begin
      d2_d = d1_q + box_s;
    end else begin
      d2_d = d1_q;
    end
  end

  always_comb begin
    tw2    = d2_q <<< 1;
    err3_d = ctl2_q.used && ctl2_q.periodic &&
             ((ctl2_q.vec ? (tw2 >= box_s) : (tw2 > box_s)) || (tw2 < nbox_s));
    absd   = (d2_q < 0) ? -d2_q : d2_q;
    mag3_d = absd[MW-1:0];
  end

  assign mh   = mag3_q[MW-1:H];
  assign ml   = mag3_q[H-1:0];
  assign hh_d = (2*HW)'(mh) * (2*HW)'(mh);
  assign hl_d = (HW+H)'(mh) * (HW+H)'(ml);
  assign ll_d = (2*H)'(ml) * (2*H)'(ml);

  assign sq5_d = (SQ_W'(hh_q) << (2*H)) + (SQ_W'(hl_q) << (H+1)) + SQ_W'(ll_q);

  always_ff @(posedge clk_i) begin
    d1_q   <= d1_d;
    ctl1_q <= ctl_i;
    d2_q   <= d2_d;
    ctl2_q <= ctl1_q;
    d3_q   <= d2_q;
    err3_q <= err3_d;
    mag3_q <= mag3_d;
    d4_q   <= d3_q;
    err4_q <= err3_q;
    hh_q   <= hh_d;
    hl_q   <= hl_d;
    ll_q   <= ll_d;
    d5_q   <= d4_q;
    err5_q <= err4_q;
    sq5_q  <= sq5_d;
  end

  assign diff_o = d5_q;
  assign err_o  = err5_q;
  assign sq_o   = sq5_q;

endmodule

// ----- hw/rtl/pmid_isqrt.sv -----
// pipelined floor integer square root, one root bit per stage, with side data
// depends on nothing outside this file
module pmid_isqrt #(
  parameter int RW     = 66,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [RW-1:0]     rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [RW/2-1:0]   root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int QW = RW / 2;

  logic [RW-1:0]     rad_in  [QW];
  logic [QW+1:0]     rem_in  [QW];
  logic [QW-1:0]     root_in [QW];
  logic              vld_in  [QW];
  logic [SIDE_W-1:0] side_in [QW];

  logic [RW-1:0]     rad_d  [QW];
  logic [QW+1:0]     rem_d  [QW];
  logic [QW-1:0]     root_d [QW];

  logic [RW-1:0]     rad_q  [QW];
  logic [QW+1:0]     rem_q  [QW];
  logic [QW-1:0]     root_q [QW];
  logic              vld_q  [QW];
  logic [SIDE_W-1:0] side_q [QW];

  always_comb begin
    rad_in[0]  = rad_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    vld_in[0]  = vld_i;
    side_in[0] = side_i;
    for (int k = 1; k < QW; k++) begin
      rad_in[k]  = rad_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      vld_in[k]  = vld_q[k-1];
      side_in[k] = side_q[k-1];
    end
  end

  // restoring digit step: bring down two radicand bits, try root*4+1
  always_comb begin
    logic [QW+1:0] rem_sh;
    logic [QW+1:0] trial;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      rem_sh    = {rem_in[k][QW-1:0], rad_in[k][RW-1:RW-2]};
      trial     = {root_in[k], 2'b01};
      ge        = rem_sh >= trial;
      rem_d[k]  = ge ? (rem_sh - trial) : rem_sh;
      root_d[k] = {root_in[k][QW-2:0], ge};
      rad_d[k]  = rad_in[k] << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QW; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < QW; k++) begin
        vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QW; k++) begin
      rad_q[k]  <= rad_d[k];
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      side_q[k] <= side_in[k];
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign root_o = root_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

// ----- hw/rtl/pmid_merge.sv -----
// merge stage: sums lane squares, selects per-kind results, runs the root pipeline
// depends on pmid_pkg and pmid_isqrt
module pmid_merge #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  pmid_pkg::ctrl_t                                ctrl_i,
  input  logic signed [pmid_pkg::fold_w(COORD_BITS)-1:0] diff_i [pmid_pkg::NUM_AXES],
  input  logic                                           err_i  [pmid_pkg::NUM_AXES],
  input  logic [2*pmid_pkg::mag_w(COORD_BITS)-1:0]       sq_i   [pmid_pkg::NUM_AXES],
  output logic                                           done_o,
  output logic signed [COORD_BITS+1:0]                   distance_o,
  output logic signed [COORD_BITS:0]                     vec_x_o,
  output logic signed [COORD_BITS:0]                     vec_y_o,
  output logic signed [COORD_BITS:0]                     vec_z_o,
  output logic                                           range_error_o
);

  localparam int MW     = pmid_pkg::mag_w(COORD_BITS);
  localparam int RW     = 2 * MW + 2;
  localparam int QW     = RW / 2;
  localparam int DIST_W = COORD_BITS + 2;
  localparam int VEC_W  = COORD_BITS + 1;
  localparam int SIDE_W = 2 + DIST_W + 3 * VEC_W;
  localparam int WIDE_W = (QW > DIST_W) ? QW : DIST_W;

  logic [RW-1:0]     sum_d, sum_q;
  logic [SIDE_W-1:0] side_d, side_q;
  logic              vld_q;

  logic              norm_d, err_d;
  logic [DIST_W-1:0] lin_d;
  logic [VEC_W-1:0]  vx_d, vy_d, vz_d;

  logic              root_vld;
  logic [QW-1:0]     root;
  logic [SIDE_W-1:0] root_side;
  logic [WIDE_W-1:0] root_ext;

  logic              norm_r, err_r;
  logic [DIST_W-1:0] lin_r;
  logic [VEC_W-1:0]  vx_r, vy_r, vz_r;

  logic              done_q;
  logic [DIST_W-1:0] distance_d, distance_q;
  logic [VEC_W-1:0]  vx_q, vy_q, vz_q;
  logic              err_q;

  assign sum_d = RW'(sq_i[0]) + RW'(sq_i[1]) + RW'(sq_i[2]);

  always_comb begin
    norm_d = 1'b0;
    lin_d  = '0;
    vx_d   = '0;
    vy_d   = '0;
    vz_d   = '0;
    err_d  = err_i[0] | err_i[1] | err_i[2];
    case (ctrl_i.kind)
      pmid_pkg::KIND_X:   lin_d = diff_i[0][DIST_W-1:0];
      pmid_pkg::KIND_Y:   lin_d = diff_i[1][DIST_W-1:0];
      pmid_pkg::KIND_Z:   lin_d = diff_i[2][DIST_W-1:0];
      pmid_pkg::KIND_XY,
      pmid_pkg::KIND_XZ,
      pmid_pkg::KIND_YZ,
      pmid_pkg::KIND_XYZ: norm_d = 1'b1;
      pmid_pkg::KIND_VEC: begin
        vx_d = diff_i[0][VEC_W-1:0];
        vy_d = diff_i[1][VEC_W-1:0];
        vz_d = diff_i[2][VEC_W-1:0];
      end
      default: norm_d = 1'b0;
    endcase
  end

  assign side_d = {norm_d, err_d, lin_d, vx_d, vy_d, vz_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    side_q <= side_d;
  end

  pmid_isqrt #(
    .RW     (RW),
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_q),
    .rad_i  (sum_q),
    .side_i (side_q),
    .vld_o  (root_vld),
    .root_o (root),
    .side_o (root_side)
  );

  assign {norm_r, err_r, lin_r, vx_r, vy_r, vz_r} = root_side;
  assign root_ext   = WIDE_W'(root);
  assign distance_d = norm_r ? root_ext[DIST_W-1:0] : lin_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= root_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    distance_q <= distance_d;
    vx_q       <= vx_r;
    vy_q       <= vy_r;
    vz_q       <= vz_r;
    err_q      <= err_r;
  end

  assign done_o        = done_q;
  assign distance_o    = signed'(distance_q);
  assign vec_x_o       = signed'(vx_q);
  assign vec_y_o       = signed'(vy_q);
  assign vec_z_o       = signed'(vz_q);
  assign range_error_o = err_q;

endmodule
